### rtl/local_binary_pattern_3x3_top_defines.svh
// ----------------------------------------------------------------------------
// Local binary pattern 3x3: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef LOCAL_BINARY_PATTERN_3X3_TOP_DEFINES_SVH
`define LOCAL_BINARY_PATTERN_3X3_TOP_DEFINES_SVH

// Check that prop holds at every clock edge out of reset.
`define LBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond never holds at a clock edge out of reset.
`define LBP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/lbp3x3_pkg.sv
// ----------------------------------------------------------------------------
// Local binary pattern 3x3: package
// Field widths, register defaults, register indexes and beat payload types.
// ----------------------------------------------------------------------------
package lbp3x3_pkg;

  localparam int PIXEL_W        = 8;
  localparam int CODE_W         = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int ROW_W          = 12;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int WIN_LAG        = 2;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = FRAME_WIDTH_W'(640);
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = FRAME_HEIGHT_W'(480);

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel;
  } pix_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              frame_end;
  } code_beat_t;

  // One line store entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    pixel_t two_above;
    pixel_t above;
  } line_pair_t;

endpackage

### rtl/lbp3x3_stream_if.sv
// ----------------------------------------------------------------------------
// Local binary pattern 3x3: stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface lbp3x3_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

### rtl/lbp3x3_linebuf.sv
// ----------------------------------------------------------------------------
// Local binary pattern 3x3: line store
// Single memory holding the two previous rows per column, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module lbp3x3_linebuf #(
  parameter int DEPTH = lbp3x3_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output lbp3x3_pkg::line_pair_t rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  lbp3x3_pkg::line_pair_t wr_data_i
);
  import lbp3x3_pkg::*;

  line_pair_t mem_q [DEPTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/local_binary_pattern_3x3_top.sv
// ----------------------------------------------------------------------------
// Local binary pattern 3x3: top level
// Streams raster pixels through a line store and a 3x3 window and emits the
// 8-neighbour pattern of every interior pixel, flagging the frame's last code.
//
//   channel   dir   beat payload           handshake
//   pix_i     in    pixel[7:0]             valid/ready
//   code_o    out   code[7:0], frame_end   valid/ready
//   cfg       in    cfg_idx_i, cfg_data_i  cfg_we_i, no wait
//
// One pixel per cycle sustained unless the output stalls; a code is
// registered at the output as its closing pixel leaves the read stage.
// Reset clears counters, window and valid bits; the line store is not
// cleared, so pixels are taken from the first cycle after reset.
// An output stall holds the line store stage, which then holds the input.
// ----------------------------------------------------------------------------
`include "local_binary_pattern_3x3_top_defines.svh"

module local_binary_pattern_3x3_top #(
  parameter int MAX_WIDTH = lbp3x3_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  lbp3x3_stream_if.sink                        pix_i,
  lbp3x3_stream_if.source                      code_o,
  input  logic                                 cfg_we_i,
  input  lbp3x3_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [lbp3x3_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lbp3x3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > FRAME_WIDTH_W) ?
                      $clog2(MAX_WIDTH + 1) : FRAME_WIDTH_W;

  // configuration
  logic [FRAME_WIDTH_W-1:0]  fw_q;
  logic [FRAME_HEIGHT_W-1:0] fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FRAME_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0]             fw_ext;
  logic [WW-1:0]             w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;

  assign fw_ext = WW'(fw_q);

  always_comb begin
    if (fw_ext < WW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (fh_q < FRAME_HEIGHT_W'(MIN_DIM)) begin
      h_eff = FRAME_HEIGHT_W'(MIN_DIM);
    end else if (fh_q > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = FRAME_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  // stage 0: position of the incoming pixel
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             last_col, last_row, emit_cur, in_acc;

  always_comb begin
    c_cur    = (WW'(col_q) >= w_eff) ? '0 : col_q;
    r_cur    = (FRAME_HEIGHT_W'(row_q) >= h_eff) ? '0 : row_q;
    last_col = (WW'(c_cur) == w_eff - WW'(1));
    last_row = (FRAME_HEIGHT_W'(r_cur) == h_eff - FRAME_HEIGHT_W'(1));
    emit_cur = (r_cur >= ROW_W'(WIN_LAG)) && (WW'(c_cur) >= WW'(WIN_LAG));
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_d = c_cur + CW'(1);
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read data, read-modify-write
  logic          s1_valid_q;
  pixel_t        s1_px_q;
  logic [CW-1:0] s1_c_q;
  logic          s1_emit_q, s1_last_q;
  logic          s1_adv, out_free, out_valid_q;
  code_beat_t    out_q;
  line_pair_t    rd_pair, wr_pair;

  assign out_free     = !out_valid_q || code_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_emit_q || out_free);
  assign pix_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc       = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pix_i.data.pixel;
      s1_c_q    <= c_cur;
      s1_emit_q <= emit_cur;
      s1_last_q <= last_row && last_col;
    end
  end

  assign wr_pair.two_above = rd_pair.above;
  assign wr_pair.above     = s1_px_q;

  lbp3x3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_cur),
    .rd_data_o (rd_pair),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_c_q),
    .wr_data_i (wr_pair)
  );

  // 3x3 window: entries 0..2 previous column, 3..5 the one before
  pixel_t            win_q [6];
  pixel_t            top, mid, bot, centre;
  logic [CODE_W-1:0] code_d;

  assign top    = rd_pair.two_above;
  assign mid    = rd_pair.above;
  assign bot    = s1_px_q;
  assign centre = win_q[1];

  always_comb begin
    code_d[0] = win_q[3] >= centre;
    code_d[1] = win_q[0] >= centre;
    code_d[2] = top      >= centre;
    code_d[3] = win_q[4] >= centre;
    code_d[4] = mid      >= centre;
    code_d[5] = win_q[5] >= centre;
    code_d[6] = win_q[2] >= centre;
    code_d[7] = bot      >= centre;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= bot;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_emit_q) begin
      out_q.code      <= code_d;
      out_q.frame_end <= s1_last_q;
    end
  end

  assign code_o.valid = out_valid_q;
  assign code_o.data  = out_q;

  // checks
  `LBP_ASSERT(a_out_from_stage1, $rose(out_valid_q) |-> $past(s1_valid_q && s1_emit_q), "output beat without a closing pixel")
  `LBP_ASSERT(a_frame_wrap, (in_acc && last_row && last_col) |=> (col_q == '0 && row_q == '0), "counters did not wrap at frame end")
  `LBP_ASSERT_NEVER(a_no_rmw_clash, in_acc && s1_valid_q && (c_cur == s1_c_q), "line store read hits pending write")

endmodule
